>>> hw/rtl/ubds_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor search package
// Shared widths, reset values, register indexes and control structs.
// ----------------------------------------------------------------------------
package ubds_pkg;

    localparam int CLK_W      = 28;
    localparam int BAUD_W     = 24;
    localparam int DIV_W      = 28;
    localparam int DIV_CNT_W  = 5;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 28;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET   = CLK_W'(48000000);
    localparam logic             FIXED_MODE_RESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_HZ   = 1'b0,
        CFG_FIXED_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DSEL_FIX  = 2'd0,
        DSEL_PER  = 2'd1,
        DSEL_CAND = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     per_load;
        logic     eval;
        logic     sbr_inc;
        logic     osr_dec;
        logic     load_fix;
        logic     load_pick;
    } t_dp_cmd;

    typedef struct packed {
        logic fixed_mode;
        logic baud_zero;
        logic div_busy;
        logic div_done;
        logic exact;
        logic sbr_last;
        logic osr_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/ubds_in_if.sv
// ----------------------------------------------------------------------------
// Baud request channel
// Valid/ready channel carrying the wanted baud rate.
// ----------------------------------------------------------------------------
interface ubds_in_if
    import ubds_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

>>> hw/rtl/ubds_out_if.sv
// ----------------------------------------------------------------------------
// Divisor result channel
// Valid/ready channel carrying the chosen oversampling and divisor fields.
// ----------------------------------------------------------------------------
interface ubds_out_if #(
    parameter int OSR_WIDTH = 5,
    parameter int SBR_WIDTH = 13
);
    logic                 valid;
    logic                 ready;
    logic [OSR_WIDTH-1:0] osr_field;
    logic [SBR_WIDTH-1:0] sbr_field;
    logic                 clipped;

    modport source (output valid, output osr_field, output sbr_field, output clipped,
                    input ready);
    modport sink   (input valid, input osr_field, input sbr_field, input clipped,
                    output ready);
endinterface

>>> hw/rtl/ubds_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module ubds_div
    import ubds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W:0]   shifted;
    logic             fits;
    logic [DIV_W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops
            r_rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> hw/rtl/ubds_dp.sv
// ----------------------------------------------------------------------------
// Baud divisor search datapath
// Config registers, divider operands, nearest-above/below trackers, output word.
// ----------------------------------------------------------------------------
module ubds_dp
    import ubds_pkg::*;
#(
    parameter int SBR_WIDTH = 13,
    parameter int OSR_WIDTH = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [BAUD_W-1:0]     i_baud_rate,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OSR_WIDTH-1:0]  o_osr_field,
    output logic [SBR_WIDTH-1:0]  o_sbr_field,
    output logic                  o_clipped
);

    localparam logic [SBR_WIDTH-1:0] SBR_MAX  = '1;
    localparam logic [SBR_WIDTH-1:0] SBR_LAST = SBR_WIDTH'((1 << SBR_WIDTH) - 2);
    localparam logic [SBR_WIDTH-1:0] SBR_ONE  = SBR_WIDTH'(1);
    localparam logic [OSR_WIDTH-1:0] OSR_ONE  = OSR_WIDTH'(1);

    logic [CLK_W-1:0]     r_clock_hz;
    logic                 r_fixed_mode;
    logic [BAUD_W-1:0]    r_baud;
    logic [OSR_WIDTH-1:0] r_osr;
    logic [SBR_WIDTH-1:0] r_sbr;
    logic [DIV_W-1:0]     r_per;
    logic [CLK_W-1:0]     r_up_rate;
    logic [OSR_WIDTH-1:0] r_up_osr;
    logic [SBR_WIDTH-1:0] r_up_sbr;
    logic [CLK_W-1:0]     r_lo_rate;
    logic [OSR_WIDTH-1:0] r_lo_osr;
    logic [SBR_WIDTH-1:0] r_lo_sbr;
    logic                 r_out_valid;
    logic [OSR_WIDTH-1:0] r_out_osr;
    logic [SBR_WIDTH-1:0] r_out_sbr;
    logic                 r_out_clip;

    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  quot;
    logic              div_busy;
    logic              div_done;

    logic [DIST_W-1:0] c32, b32, up32, lo32;
    logic              take_up, take_lo, exact, pick_lo;
    logic [DIV_W-1:0]  fix_q;
    logic              fix_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz   <= CLOCK_HZ_RESET;
            r_fixed_mode <= FIXED_MODE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CLOCK_HZ:   r_clock_hz   <= i_cfg_data[CLK_W-1:0];
                CFG_FIXED_MODE: r_fixed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_FIX: begin
                div_dividend = DIV_W'(r_clock_hz);
                div_divisor  = DIV_W'(r_baud);
            end
            DSEL_PER: begin
                div_dividend = DIV_W'(r_clock_hz);
                div_divisor  = DIV_W'(r_osr) + DIV_W'(1);
            end
            DSEL_CAND: begin
                div_dividend = r_per;
                div_divisor  = DIV_W'(r_sbr);
            end
            default: begin
                div_dividend = DIV_W'(r_clock_hz);
                div_divisor  = DIV_W'(1);
            end
        endcase
    end

    ubds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // distances wrap at 32 bits, as the upper tracker may start below the baud
    always_comb begin
        c32     = DIST_W'(quot);
        b32     = DIST_W'(r_baud);
        up32    = DIST_W'(r_up_rate);
        lo32    = DIST_W'(r_lo_rate);
        take_up = (c32 > b32) && ((c32 - b32) < (up32 - b32));
        take_lo = (c32 < b32) && ((b32 - c32) < (b32 - lo32));
        exact   = (c32 == b32);
        pick_lo = (b32 - lo32) < (up32 - b32);
        fix_q    = quot >> OSR_WIDTH;
        fix_clip = (r_baud == '0) || (fix_q > DIV_W'(SBR_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_baud    <= i_baud_rate;
            r_osr     <= '1;
            r_sbr     <= SBR_ONE;
            r_up_rate <= r_clock_hz;
            r_up_osr  <= '0;
            r_up_sbr  <= '0;
            r_lo_rate <= '0;
            r_lo_osr  <= '0;
            r_lo_sbr  <= '0;
        end else begin
            if (i_cmd.per_load) begin
                r_per <= quot;
                r_sbr <= SBR_ONE;
            end
            if (i_cmd.sbr_inc) begin
                r_sbr <= r_sbr + SBR_ONE;
            end
            if (i_cmd.osr_dec) begin
                r_osr <= r_osr - OSR_ONE;
            end
            if (i_cmd.eval) begin
                if (take_up) begin
                    r_up_rate <= quot;
                    r_up_osr  <= r_osr;
                    r_up_sbr  <= r_sbr;
                end
                if (take_lo || exact) begin
                    r_lo_rate <= quot;
                    r_lo_osr  <= r_osr;
                    r_lo_sbr  <= r_sbr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_fix || i_cmd.load_pick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fix) begin
            r_out_osr  <= '1;
            r_out_sbr  <= fix_clip ? SBR_MAX : fix_q[SBR_WIDTH-1:0];
            r_out_clip <= fix_clip;
        end else if (i_cmd.load_pick) begin
            r_out_osr  <= pick_lo ? r_lo_osr : r_up_osr;
            r_out_sbr  <= pick_lo ? r_lo_sbr : r_up_sbr;
            r_out_clip <= 1'b0;
        end
    end

    always_comb begin
        o_stat.fixed_mode = r_fixed_mode;
        o_stat.baud_zero  = (r_baud == '0);
        o_stat.div_busy   = div_busy;
        o_stat.div_done   = div_done;
        o_stat.exact      = exact;
        o_stat.sbr_last   = (r_sbr == SBR_LAST);
        o_stat.osr_last   = (r_osr == OSR_ONE);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_osr_field = r_out_osr;
    assign o_sbr_field = r_out_sbr;
    assign o_clipped   = r_out_clip;

endmodule

>>> hw/rtl/ubds_ctrl.sv
// ----------------------------------------------------------------------------
// Baud divisor search controller
// Sequences fixed-mode division or the full oversampling/divisor sweep.
// ----------------------------------------------------------------------------
module ubds_ctrl
    import ubds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIX_DIV,
        S_FIX_WAIT,
        S_FIX_DONE,
        S_PER_DIV,
        S_PER_WAIT,
        S_CAND_DIV,
        S_CAND_WAIT,
        S_EVAL,
        S_PICK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DSEL_CAND;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_stat.fixed_mode ? S_FIX_DIV : S_PER_DIV;
                end
            end
            S_FIX_DIV: begin
                // zero baud clips without dividing
                if (i_stat.baud_zero) begin
                    n_state = S_FIX_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_FIX;
                    n_state = S_FIX_WAIT;
                end
            end
            S_FIX_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FIX_DONE;
                end
            end
            S_FIX_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_fix = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PER_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_PER;
                n_state = S_PER_WAIT;
            end
            S_PER_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.per_load = 1'b1;
                    n_state = S_CAND_DIV;
                end
            end
            S_CAND_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_CAND;
                n_state = S_CAND_WAIT;
            end
            S_CAND_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.exact) begin
                    n_state = S_PICK;
                end else if (i_stat.sbr_last) begin
                    if (i_stat.osr_last) begin
                        n_state = S_PICK;
                    end else begin
                        o_cmd.osr_dec = 1'b1;
                        n_state = S_PER_DIV;
                    end
                end else begin
                    o_cmd.sbr_inc = 1'b1;
                    n_state = S_CAND_DIV;
                end
            end
            S_PICK: begin
                if (i_stat.out_free) begin
                    o_cmd.load_pick = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/uart_baud_divisor_search_top.sv
// ----------------------------------------------------------------------------
// UART baud divisor search, top level
// Fixed mode: one 28-step division per word; a zero baud clips without
// dividing.
// Search mode: one division per oversampling step and one per candidate, up
// to 31 oversampling steps of 8190 candidates each; an exact match ends early.
// One word in flight; the next word is taken while a result waits at the output.
// Synchronous active-low reset restores clock_hz to 48 MHz and fixed mode on.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_top
    import ubds_pkg::*;
#(
    parameter int SBR_WIDTH = 13,
    parameter int OSR_WIDTH = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ubds_in_if.sink               i_in,
    ubds_out_if.source            o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    ubds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ubds_dp #(
        .SBR_WIDTH (SBR_WIDTH),
        .OSR_WIDTH (OSR_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_baud_rate (i_in.baud_rate),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_osr_field (o_out.osr_field),
        .o_sbr_field (o_out.sbr_field),
        .o_clipped   (o_out.clipped)
    );

    assign i_in.ready = in_ready;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !stat.div_busy)
        else $error("word accepted during a division");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_fix || cmd.load_pick) |-> (!o_out.valid || o_out.ready))
        else $error("result overwrote a waiting word");

    a_clip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clipped) |-> (o_out.sbr_field == '1))
        else $error("clipped result without full divisor");

endmodule

>>> dv/tb_uart_baud_divisor_search_top.sv
// ----------------------------------------------------------------------------
// UART baud divisor search testbench
// Drives wanted baud rates over the request channel under several clock and
// mode settings. A scoreboard predicts the oversampling and divisor fields in
// fixed and search mode and checks each result word in order. Random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_uart_baud_divisor_search_top;
    import ubds_pkg::*;

    localparam int OSR_W     = 5;
    localparam int SBR_W     = 13;
    localparam int OSR_FULL  = (1 << OSR_W) - 1;
    localparam int SBR_FULL  = (1 << SBR_W) - 1;
    localparam int OSR_RATIO = OSR_FULL + 1;

    typedef struct packed {
        logic [OSR_W-1:0] osr;
        logic [SBR_W-1:0] sbr;
        logic             clip;
    } divisor_t;

    typedef struct {
        logic [BAUD_W-1:0] baud;
        divisor_t          pick;
    } pending_t;

    class baud_divisor_ledger;
        logic [CLK_W-1:0] clock_hz;
        bit               fixed_mode;
        pending_t         pending[$];
        int               errors;
        int               checked;
        int               searched;
        int               clipped_seen;
        int               settings;

        function new();
            clock_hz     = CLOCK_HZ_RESET;
            fixed_mode   = FIXED_MODE_RESET;
            errors       = 0;
            checked      = 0;
            searched     = 0;
            clipped_seen = 0;
            settings     = 1;
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CLOCK_HZ) begin
                clock_hz = data[CLK_W-1:0];
            end else begin
                fixed_mode = data[0];
            end
        endfunction

        // Sweep the pairs until an exact hit, track the nearest rate on each side of the target.
        function divisor_t nearest_pair(input bit [31:0] baud);
            bit [31:0] clk;
            bit [31:0] per_div;
            bit [31:0] cand;
            bit [31:0] up_rate;
            bit [31:0] lo_rate;
            divisor_t  up;
            divisor_t  lo;
            bit        hit;
            int        osr;
            int        sbr;
            clk     = 32'(clock_hz);
            up_rate = clk;
            lo_rate = '0;
            up      = '0;
            lo      = '0;
            hit     = 1'b0;
            for (osr = OSR_FULL; osr > 0 && !hit; osr--) begin
                per_div = clk / 32'(osr + 1);
                for (sbr = 1; sbr < SBR_FULL && !hit; sbr++) begin
                    cand = per_div / 32'(sbr);
                    if (cand > baud && (cand - baud) < (up_rate - baud)) begin
                        up_rate = cand;
                        up.osr  = OSR_W'(osr);
                        up.sbr  = SBR_W'(sbr);
                    end
                    if (cand < baud && (baud - cand) < (baud - lo_rate)) begin
                        lo_rate = cand;
                        lo.osr  = OSR_W'(osr);
                        lo.sbr  = SBR_W'(sbr);
                    end
                    // exact hit lands in the lower slot and stops the sweep
                    if (cand == baud) begin
                        lo_rate = cand;
                        lo.osr  = OSR_W'(osr);
                        lo.sbr  = SBR_W'(sbr);
                        hit     = 1'b1;
                    end
                end
            end
            return ((baud - lo_rate) < (up_rate - baud)) ? lo : up;
        endfunction

        function divisor_t pick_divisors(input logic [BAUD_W-1:0] baud);
            divisor_t         res;
            logic [CLK_W-1:0] quot;
            res = '0;
            if (!fixed_mode) begin
                return nearest_pair(32'(baud));
            end
            res.osr = OSR_W'(OSR_FULL);
            if (baud == '0) begin
                res.sbr  = SBR_W'(SBR_FULL);
                res.clip = 1'b1;
            end else begin
                quot = clock_hz / CLK_W'(baud) / CLK_W'(OSR_RATIO);
                if (quot > SBR_FULL) begin
                    res.sbr  = SBR_W'(SBR_FULL);
                    res.clip = 1'b1;
                end else begin
                    res.sbr = SBR_W'(quot);
                end
            end
            return res;
        endfunction

        function void note_baud(input logic [BAUD_W-1:0] baud);
            pending_t item;
            item.baud = baud;
            item.pick = pick_divisors(baud);
            if (!fixed_mode) searched++;
            if (item.pick.clip) clipped_seen++;
            pending.push_back(item);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 20) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(input divisor_t got);
            pending_t want;
            if (pending.size() == 0) begin
                report($sformatf("result word osr=%0d sbr=%0d clip=%0d with nothing pending",
                                 got.osr, got.sbr, got.clip));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.osr !== want.pick.osr)
                report($sformatf("baud %0d: osr_field %0d, want %0d",
                                 want.baud, got.osr, want.pick.osr));
            if (got.sbr !== want.pick.sbr)
                report($sformatf("baud %0d: sbr_field %0d, want %0d",
                                 want.baud, got.sbr, want.pick.sbr));
            if (got.clip !== want.pick.clip)
                report($sformatf("baud %0d: clipped %0d, want %0d",
                                 want.baud, got.clip, want.pick.clip));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ubds_in_if in_if ();
    ubds_out_if #(.OSR_WIDTH(OSR_W), .SBR_WIDTH(SBR_W)) out_if ();

    baud_divisor_ledger ledger;
    bit                 steady;

    uart_baud_divisor_search_top #(
        .SBR_WIDTH(SBR_W),
        .OSR_WIDTH(OSR_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #400_000_000;
        $display("tb_uart_baud_divisor_search_top failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none in steady stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (steady || r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_side
        int hold;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                @(negedge i_clk);
                out_if.ready = 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_if.ready = 1'b1;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            ledger.check_result({out_if.osr_field, out_if.sbr_field, out_if.clipped});
        end
    end

    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.baud_rate = baud;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        ledger.note_baud(baud);
    endtask

    // Drop the request and hold until every pending result is back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        ledger.write_reg(idx, data);
    endtask

    task automatic retune(input logic [CLK_W-1:0] clk, input bit mode);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word    = CFG_DATA_W'($urandom());
        mode_word[0] = mode;
        wait_drained();
        write_reg(CFG_CLOCK_HZ, CFG_DATA_W'(clk));
        write_reg(CFG_FIXED_MODE, mode_word);
        ledger.settings++;
    endtask

    initial begin : stimulus
        logic [CLK_W-1:0]  clk;
        logic [CLK_W-1:0]  per_div;
        logic [BAUD_W-1:0] baud;
        bit                mode;
        int                ph;
        int                n;
        int                r;
        ledger          = new();
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_CLOCK_HZ;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.baud_rate = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: 48 MHz, fixed oversampling
        send_baud(24'd115200);
        send_baud(24'd9600);
        send_baud(24'd1);
        send_baud(24'd0);
        send_baud(24'd183);
        send_baud(24'd184);
        send_baud(24'd16000000);
        send_baud(24'hFFFFFF);

        retune({CLK_W{1'b1}}, 1'b1);
        send_baud(24'd1);
        send_baud(24'h800000);
        send_baud(24'd7);

        // zero clock: every rate is zero
        retune('0, 1'b1);
        send_baud(24'd5);
        // clock equal to baud with no rate above: upper side wins with zero fields
        retune('0, 1'b0);
        send_baud(24'd0);

        retune(CLK_W'(100), 1'b0);
        send_baud(24'd0);
        send_baud(24'd3);
        send_baud(24'd1);

        retune(CLK_W'(1), 1'b0);
        send_baud(24'd0);

        retune({CLK_W{1'b1}}, 1'b0);
        send_baud(24'd8388607);

        // second value misses every pair at the top ratio and hits one step down
        retune(CLK_W'(48000000), 1'b0);
        send_baud(24'd1500000);
        send_baud(24'd1548387);

        // no exact pair: full sweep, nearest above against nearest below
        retune(CLK_W'(1000000), 1'b0);
        send_baud(24'd300000);

        for (ph = 0; ph < 8; ph++) begin
            steady = (ph % 3 == 2);
            case ($urandom_range(0, 4))
                0:       clk = CLK_W'($urandom_range(1, 2000));
                1:       clk = {CLK_W{1'b1}};
                2:       clk = CLK_W'($urandom_range(1, 200000000));
                default: clk = CLK_W'($urandom());
            endcase
            mode = (ph < 2) ? ph[0] : bit'($urandom_range(0, 1));
            retune(clk, mode);
            per_div = clk / CLK_W'(OSR_RATIO);
            for (n = 0; n < 13; n++) begin
                r = $urandom_range(0, 9);
                if (mode) begin
                    case (r % 6)
                        0, 1: baud = BAUD_W'($urandom());
                        2:    baud = BAUD_W'($urandom_range(1, 4000));
                        3:    baud = BAUD_W'(clk / CLK_W'(OSR_RATIO * (SBR_FULL + 1))
                                             + CLK_W'($urandom_range(0, 2)));
                        4:    baud = $urandom_range(0, 1) ? '0 : {BAUD_W{1'b1}};
                        default: baud = BAUD_W'($urandom_range(1, 16000000));
                    endcase
                end else if (r == 0 && per_div < 64) begin
                    baud = '0;
                end else begin
                    // land on an exact pair early in the sweep
                    baud = BAUD_W'(per_div / CLK_W'((r == 1) ? $urandom_range(1, 200)
                                                            : $urandom_range(1, 24)));
                end
                send_baud(baud);
                if (n == 6) wait_drained();
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("checked %0d result words over %0d register settings", ledger.checked,
                 ledger.settings);
        $display("%0d in search mode, %0d with the divisor clipped", ledger.searched,
                 ledger.clipped_seen);
        if (ledger.errors == 0) begin
            $display("tb_uart_baud_divisor_search_top passed");
        end else begin
            $display("tb_uart_baud_divisor_search_top failed");
        end
        $finish;
    end

endmodule
